// File: rtl/acri_pkg.sv
// Shared types and constants of the ATA CHS request issuer.
// Used by the divider cells, the output sequencer and the top level.
package acri_pkg;

	// Fixed field widths
	localparam int MINOR_W      = 4;
	localparam int SECTOR_W     = 32;
	localparam int COUNT_W      = 8;
	localparam int HEADS_W      = 5;
	localparam int SPT_W        = 6;
	localparam int PRECOMP_W    = 10;
	localparam int BYTE_W       = 8;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 10;

	// Divider data path: remainder and divisor hold up to 31 * 63
	localparam int REM_W        = 11;
	localparam int STEP_BITS    = 4;
	localparam int CYL_DW       = 32;
	localparam int HEAD_DW      = 12;
	localparam int CYL_OUT_W    = 16;

	// A request that passes its checks makes this many task-file writes
	localparam int RESULTS_PER_REQ = 8;
	localparam int GAP_W           = $clog2(RESULTS_PER_REQ);

	// Item function codes
	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_REQUEST = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_MINOR = 2'd1;
	localparam logic [1:0] ST_BAD_RANGE = 2'd2;
	localparam logic [1:0] ST_BAD_GEOM  = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_HEADS0   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPT0     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEADS1   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPT1     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_PRECOMP0 = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_PRECOMP1 = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_CTRL0    = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_CTRL1    = 3'd7;

	// Configuration reset values
	localparam logic [HEADS_W-1:0] HEADS_RESET = 5'd16;
	localparam logic [SPT_W-1:0]   SPT_RESET   = 6'd63;

	// Task-file register offsets
	localparam logic [2:0] REG_NONE     = 3'd0;
	localparam logic [2:0] REG_PRECOMP  = 3'd1;
	localparam logic [2:0] REG_COUNT    = 3'd2;
	localparam logic [2:0] REG_SECTOR   = 3'd3;
	localparam logic [2:0] REG_CYL_LO   = 3'd4;
	localparam logic [2:0] REG_CYL_HI   = 3'd5;
	localparam logic [2:0] REG_DRV_HEAD = 3'd6;
	localparam logic [2:0] REG_CMD      = 3'd7;

	// Task-file byte constants
	localparam logic [BYTE_W-1:0] CMD_READ     = 8'h20;
	localparam logic [BYTE_W-1:0] CMD_WRITE    = 8'h30;
	localparam logic [BYTE_W-1:0] DRVHEAD_BASE = 8'ha0;
	localparam int                HEAD_MAX     = 15;

	// Order of the writes for one request
	typedef enum logic [2:0] {
		BEAT_CTL,
		BEAT_PRECOMP,
		BEAT_COUNT,
		BEAT_SECTOR,
		BEAT_CYL_LO,
		BEAT_CYL_HI,
		BEAT_DRV_HEAD,
		BEAT_CMD
	} beat_t;

	typedef struct packed {
		logic                func;
		logic [MINOR_W-1:0]  minor;
		logic [SECTOR_W-1:0] part_start;
		logic [SECTOR_W-1:0] part_size;
		logic [SECTOR_W-1:0] req_block;
		logic [COUNT_W-1:0]  req_count;
		logic                write_not_read;
	} req_t;

	typedef struct packed {
		logic [2:0]        port_offset;
		logic [BYTE_W-1:0] port_data;
		logic [1:0]        status;
		logic              last;
	} rsp_t;

	// Sideband through the cylinder divider
	typedef struct packed {
		logic [1:0]         status;
		logic               drive;
		logic [COUNT_W-1:0] count;
		logic               wr;
		logic [BYTE_W-1:0]  ctl;
		logic [BYTE_W-1:0]  pre;
		logic [SPT_W-1:0]   spt;
	} side_cyl_t;

	// Sideband through the head divider
	typedef struct packed {
		logic [1:0]           status;
		logic                 drive;
		logic [COUNT_W-1:0]   count;
		logic                 wr;
		logic [BYTE_W-1:0]    ctl;
		logic [BYTE_W-1:0]    pre;
		logic [CYL_OUT_W-1:0] cyl;
	} side_head_t;

	// A finished request, ready to be sent as task-file writes
	typedef struct packed {
		logic [1:0]        status;
		logic [BYTE_W-1:0] ctl;
		logic [BYTE_W-1:0] pre;
		logic [BYTE_W-1:0] count;
		logic [BYTE_W-1:0] sect;
		logic [BYTE_W-1:0] cyl_lo;
		logic [BYTE_W-1:0] cyl_hi;
		logic [BYTE_W-1:0] drv_head;
		logic [BYTE_W-1:0] cmd;
	} issue_t;

endpackage

// File: rtl/acri_div_cell.sv
// One cell of the restoring divider chain: STEP_BITS quotient bits per cycle.
// Depends on acri_pkg for the remainder width and step count.
module acri_div_cell #(
	parameter int  DW     = 32,
	parameter type side_t = logic
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_in,
	input  logic [DW-1:0]              dq_in,
	input  logic [acri_pkg::REM_W-1:0] rem_in,
	input  logic [acri_pkg::REM_W-1:0] divisor_in,
	input  side_t                      side_in,
	output logic                       valid_out,
	output logic [DW-1:0]              dq_out,
	output logic [acri_pkg::REM_W-1:0] rem_out,
	output logic [acri_pkg::REM_W-1:0] divisor_out,
	output side_t                      side_out
);

	logic                       valid_q;
	logic [DW-1:0]              dq_q;
	logic [acri_pkg::REM_W-1:0] rem_q;
	logic [acri_pkg::REM_W-1:0] divisor_q;
	side_t                      side_q;

	logic [acri_pkg::REM_W:0]   trial;
	logic [acri_pkg::REM_W-1:0] rem_n;
	logic [DW-1:0]              dq_n;

	// Shift in dividend bits, subtract the divisor where it fits
	always_comb begin
		rem_n = rem_in;
		dq_n  = dq_in;
		trial = '0;
		for (int i = 0; i < acri_pkg::STEP_BITS; i++) begin
			trial = {rem_n, dq_n[DW-1]};
			dq_n  = {dq_n[DW-2:0], 1'b0};
			if (trial >= {1'b0, divisor_in}) begin
				trial   = trial - {1'b0, divisor_in};
				dq_n[0] = 1'b1;
			end
			rem_n = trial[acri_pkg::REM_W-1:0];
		end
	end

	// Advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_in;
		end
	end

	// Hand the partial result to the next cell
	always_ff @(posedge clk) begin
		dq_q      <= dq_n;
		rem_q     <= rem_n;
		divisor_q <= divisor_in;
		side_q    <= side_in;
	end

	assign valid_out   = valid_q;
	assign dq_out      = dq_q;
	assign rem_out     = rem_q;
	assign divisor_out = divisor_q;
	assign side_out    = side_q;

`ifndef NO_ASSERTIONS
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && divisor_q != '0 |-> rem_q < divisor_q)
		else $error("partial remainder not below divisor");
`endif

endmodule

// File: rtl/acri_out_seq.sv
// Output sequencer: sends a finished request as eight task-file writes,
// or a rejected one as a single error item. Depends on acri_pkg.
module acri_out_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  acri_pkg::issue_t rec,
	output logic             valid,
	output acri_pkg::rsp_t   rsp
);

	logic             active_q;
	acri_pkg::beat_t  beat_q;
	acri_pkg::issue_t rec_q;
	logic             is_err;
	logic             last_beat;

	assign is_err    = rec_q.status != acri_pkg::ST_OK;
	assign last_beat = is_err || beat_q == acri_pkg::BEAT_CMD;

	// Step through the writes, restart on a new request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			beat_q   <= acri_pkg::BEAT_CTL;
		end else if (load) begin
			active_q <= 1'b1;
			beat_q   <= acri_pkg::BEAT_CTL;
		end else if (active_q) begin
			if (last_beat) begin
				active_q <= 1'b0;
			end else begin
				beat_q <= acri_pkg::beat_t'(beat_q + 3'd1);
			end
		end
	end

	// Hold the request being sent
	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= rec;
		end
	end

	// Pick the register and byte of the current write
	always_comb begin
		rsp.status = rec_q.status;
		rsp.last   = last_beat;
		case (beat_q)
			acri_pkg::BEAT_CTL: begin
				rsp.port_offset = acri_pkg::REG_CMD;
				rsp.port_data   = rec_q.ctl;
			end
			acri_pkg::BEAT_PRECOMP: begin
				rsp.port_offset = acri_pkg::REG_PRECOMP;
				rsp.port_data   = rec_q.pre;
			end
			acri_pkg::BEAT_COUNT: begin
				rsp.port_offset = acri_pkg::REG_COUNT;
				rsp.port_data   = rec_q.count;
			end
			acri_pkg::BEAT_SECTOR: begin
				rsp.port_offset = acri_pkg::REG_SECTOR;
				rsp.port_data   = rec_q.sect;
			end
			acri_pkg::BEAT_CYL_LO: begin
				rsp.port_offset = acri_pkg::REG_CYL_LO;
				rsp.port_data   = rec_q.cyl_lo;
			end
			acri_pkg::BEAT_CYL_HI: begin
				rsp.port_offset = acri_pkg::REG_CYL_HI;
				rsp.port_data   = rec_q.cyl_hi;
			end
			acri_pkg::BEAT_DRV_HEAD: begin
				rsp.port_offset = acri_pkg::REG_DRV_HEAD;
				rsp.port_data   = rec_q.drv_head;
			end
			acri_pkg::BEAT_CMD: begin
				rsp.port_offset = acri_pkg::REG_CMD;
				rsp.port_data   = rec_q.cmd;
			end
			default: begin
				rsp.port_offset = acri_pkg::REG_NONE;
				rsp.port_data   = '0;
			end
		endcase
		// Error item: no register, no data
		if (is_err) begin
			rsp.port_offset = acri_pkg::REG_NONE;
			rsp.port_data   = '0;
		end
	end

	assign valid = active_q;

`ifndef NO_ASSERTIONS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !active_q || last_beat)
		else $error("new request arrived while writes still pending");
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid && rsp.status != acri_pkg::ST_OK |-> rsp.last && rsp.port_offset == '0)
		else $error("error item is not a single final item");
`endif

endmodule

// File: rtl/ata_chs_request_issuer_core.sv
// A request passes the request register, the check stage, the cylinder and head
// divider cells and the output sequencer, then its writes follow at one write per
// cycle (a rejection gives one item instead). Busy spaces requests by the eight
// writes on the result port; a load does not raise busy.
// Results are sent on fixed cycles and cannot be held off by the receiver.
// Reset clears the partition table and sets geometry to 16 heads, 63 sectors.
module ata_chs_request_issuer_core #(
	parameter int NUM_DRIVES       = 2,
	parameter int MINORS_PER_DRIVE = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  acri_pkg::req_t                      req,
	input  logic                                cfg_we,
	input  logic [acri_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [acri_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                rsp_valid,
	output acri_pkg::rsp_t                      rsp
);

	localparam int TABLE_DEPTH = NUM_DRIVES * MINORS_PER_DRIVE;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int N_CYL       = acri_pkg::CYL_DW / acri_pkg::STEP_BITS;
	localparam int N_HEAD      = acri_pkg::HEAD_DW / acri_pkg::STEP_BITS;

	// Configuration registers
	logic [acri_pkg::HEADS_W-1:0]   heads0_q, heads1_q;
	logic [acri_pkg::SPT_W-1:0]     spt0_q, spt1_q;
	logic [acri_pkg::PRECOMP_W-1:0] precomp0_q, precomp1_q;
	logic [acri_pkg::BYTE_W-1:0]    ctrl0_q, ctrl1_q;

	// Partition table
	logic [acri_pkg::SECTOR_W-1:0] start_tab_q [TABLE_DEPTH];
	logic [acri_pkg::SECTOR_W-1:0] size_tab_q  [TABLE_DEPTH];

	logic [acri_pkg::GAP_W-1:0] gap_q;
	logic                       accept;
	logic                       in_minor_ok;

	// Stage 1: registered request
	logic                                valid_s1;
	logic [acri_pkg::MINOR_W-1:0]        minor_s1;
	logic [acri_pkg::SECTOR_W-1:0]       block_s1;
	logic [acri_pkg::COUNT_W-1:0]        count_s1;
	logic                                wr_s1;

	// Stage 2: checks, table read, start addition, geometry
	logic                                minor_ok;
	logic [IDX_W-1:0]                    idx;
	logic [acri_pkg::SECTOR_W-1:0]       start_rd, size_rd;
	logic                                range_bad;
	logic                                drive;
	logic [acri_pkg::HEADS_W-1:0]        heads_sel;
	logic [acri_pkg::SPT_W-1:0]          spt_sel;
	logic [acri_pkg::PRECOMP_W-1:0]      precomp_sel;
	logic [acri_pkg::BYTE_W-1:0]         ctrl_sel;
	logic [1:0]                          status_pre;
	logic                                valid_s2;
	logic [acri_pkg::SECTOR_W-1:0]       abs_s2;
	logic [acri_pkg::REM_W-1:0]          track_s2;
	acri_pkg::side_cyl_t                 side_s2;

	// Divider chains
	logic                          cyl_valid [N_CYL+1];
	logic [acri_pkg::CYL_DW-1:0]   cyl_dq    [N_CYL+1];
	logic [acri_pkg::REM_W-1:0]    cyl_rem   [N_CYL+1];
	logic [acri_pkg::REM_W-1:0]    cyl_div   [N_CYL+1];
	acri_pkg::side_cyl_t           cyl_side  [N_CYL+1];

	logic                          head_valid [N_HEAD+1];
	logic [acri_pkg::HEAD_DW-1:0]  head_dq    [N_HEAD+1];
	logic [acri_pkg::REM_W-1:0]    head_rem   [N_HEAD+1];
	logic [acri_pkg::REM_W-1:0]    head_div   [N_HEAD+1];
	acri_pkg::side_head_t          head_side  [N_HEAD+1];

	logic [acri_pkg::HEAD_DW-1:0]  head_val;
	acri_pkg::side_head_t          side_fin;
	acri_pkg::issue_t              issue;

	assign accept      = start && !busy;
	assign busy        = gap_q != '0;
	assign in_minor_ok = 6'(req.minor) < 6'(TABLE_DEPTH);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heads0_q   <= acri_pkg::HEADS_RESET;
			heads1_q   <= acri_pkg::HEADS_RESET;
			spt0_q     <= acri_pkg::SPT_RESET;
			spt1_q     <= acri_pkg::SPT_RESET;
			precomp0_q <= '0;
			precomp1_q <= '0;
			ctrl0_q    <= '0;
			ctrl1_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				acri_pkg::CFG_HEADS0:   heads0_q   <= cfg_data[acri_pkg::HEADS_W-1:0];
				acri_pkg::CFG_SPT0:     spt0_q     <= cfg_data[acri_pkg::SPT_W-1:0];
				acri_pkg::CFG_HEADS1:   heads1_q   <= cfg_data[acri_pkg::HEADS_W-1:0];
				acri_pkg::CFG_SPT1:     spt1_q     <= cfg_data[acri_pkg::SPT_W-1:0];
				acri_pkg::CFG_PRECOMP0: precomp0_q <= cfg_data[acri_pkg::PRECOMP_W-1:0];
				acri_pkg::CFG_PRECOMP1: precomp1_q <= cfg_data[acri_pkg::PRECOMP_W-1:0];
				acri_pkg::CFG_CTRL0:    ctrl0_q    <= cfg_data[acri_pkg::BYTE_W-1:0];
				acri_pkg::CFG_CTRL1:    ctrl1_q    <= cfg_data[acri_pkg::BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// Load partition entries; drop loads with a bad minor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				start_tab_q[i] <= '0;
				size_tab_q[i]  <= '0;
			end
		end else if (accept && req.func == acri_pkg::FUNC_LOAD && in_minor_ok) begin
			start_tab_q[IDX_W'(req.minor)] <= req.part_start;
			size_tab_q[IDX_W'(req.minor)]  <= req.part_size;
		end
	end

	// Space requests by the number of writes a full request sends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (accept && req.func == acri_pkg::FUNC_REQUEST) begin
			gap_q <= acri_pkg::GAP_W'(acri_pkg::RESULTS_PER_REQ - 1);
		end else if (gap_q != '0) begin
			gap_q <= gap_q - 1'b1;
		end
	end

	// Stage 1: capture the request item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && req.func == acri_pkg::FUNC_REQUEST;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			minor_s1 <= req.minor;
			block_s1 <= req.req_block;
			count_s1 <= req.req_count;
			wr_s1    <= req.write_not_read;
		end
	end

	// Stage 2: validate, add the partition start, select drive geometry
	always_comb begin
		minor_ok  = 6'(minor_s1) < 6'(TABLE_DEPTH);
		idx       = IDX_W'(minor_s1);
		start_rd  = minor_ok ? start_tab_q[idx] : '0;
		size_rd   = minor_ok ? size_tab_q[idx] : '0;
		range_bad = count_s1 == '0 ||
			({1'b0, block_s1} + 33'(count_s1)) > {1'b0, size_rd};
		drive     = (NUM_DRIVES > 1) && (5'(minor_s1) >= 5'(MINORS_PER_DRIVE));
		if (drive) begin
			heads_sel   = heads1_q;
			spt_sel     = spt1_q;
			precomp_sel = precomp1_q;
			ctrl_sel    = ctrl1_q;
		end else begin
			heads_sel   = heads0_q;
			spt_sel     = spt0_q;
			precomp_sel = precomp0_q;
			ctrl_sel    = ctrl0_q;
		end
		if (!minor_ok) begin
			status_pre = acri_pkg::ST_BAD_MINOR;
		end else if (range_bad) begin
			status_pre = acri_pkg::ST_BAD_RANGE;
		end else if (heads_sel == '0 || spt_sel == '0) begin
			status_pre = acri_pkg::ST_BAD_GEOM;
		end else begin
			status_pre = acri_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		abs_s2         <= block_s1 + start_rd;
		track_s2       <= acri_pkg::REM_W'(heads_sel) * acri_pkg::REM_W'(spt_sel);
		side_s2.status <= status_pre;
		side_s2.drive  <= drive;
		side_s2.count  <= count_s1;
		side_s2.wr     <= wr_s1;
		side_s2.ctl    <= ctrl_sel;
		side_s2.pre    <= precomp_sel[acri_pkg::PRECOMP_W-1:2];
		side_s2.spt    <= spt_sel;
	end

	// Cylinder chain: absolute sector over sectors per cylinder
	assign cyl_valid[0] = valid_s2;
	assign cyl_dq[0]    = abs_s2;
	assign cyl_rem[0]   = '0;
	assign cyl_div[0]   = track_s2;
	assign cyl_side[0]  = side_s2;

	for (genvar g = 0; g < N_CYL; g++) begin : g_cyl
		acri_div_cell #(
			.DW     (acri_pkg::CYL_DW),
			.side_t (acri_pkg::side_cyl_t)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.valid_in    (cyl_valid[g]),
			.dq_in       (cyl_dq[g]),
			.rem_in      (cyl_rem[g]),
			.divisor_in  (cyl_div[g]),
			.side_in     (cyl_side[g]),
			.valid_out   (cyl_valid[g+1]),
			.dq_out      (cyl_dq[g+1]),
			.rem_out     (cyl_rem[g+1]),
			.divisor_out (cyl_div[g+1]),
			.side_out    (cyl_side[g+1])
		);
	end

	// Head chain: cylinder remainder over sectors per track
	assign head_valid[0]       = cyl_valid[N_CYL];
	assign head_dq[0]          = acri_pkg::HEAD_DW'(cyl_rem[N_CYL]);
	assign head_rem[0]         = '0;
	assign head_div[0]         = acri_pkg::REM_W'(cyl_side[N_CYL].spt);
	assign head_side[0].status = cyl_side[N_CYL].status;
	assign head_side[0].drive  = cyl_side[N_CYL].drive;
	assign head_side[0].count  = cyl_side[N_CYL].count;
	assign head_side[0].wr     = cyl_side[N_CYL].wr;
	assign head_side[0].ctl    = cyl_side[N_CYL].ctl;
	assign head_side[0].pre    = cyl_side[N_CYL].pre;
	assign head_side[0].cyl    = cyl_dq[N_CYL][acri_pkg::CYL_OUT_W-1:0];

	for (genvar g = 0; g < N_HEAD; g++) begin : g_head
		acri_div_cell #(
			.DW     (acri_pkg::HEAD_DW),
			.side_t (acri_pkg::side_head_t)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.valid_in    (head_valid[g]),
			.dq_in       (head_dq[g]),
			.rem_in      (head_rem[g]),
			.divisor_in  (head_div[g]),
			.side_in     (head_side[g]),
			.valid_out   (head_valid[g+1]),
			.dq_out      (head_dq[g+1]),
			.rem_out     (head_rem[g+1]),
			.divisor_out (head_div[g+1]),
			.side_out    (head_side[g+1])
		);
	end

	// Build the task-file bytes; reject a head beyond the drive/head field
	assign head_val = head_dq[N_HEAD];
	assign side_fin = head_side[N_HEAD];

	always_comb begin
		if (side_fin.status != acri_pkg::ST_OK) begin
			issue.status = side_fin.status;
		end else if (head_val > acri_pkg::HEAD_DW'(acri_pkg::HEAD_MAX)) begin
			issue.status = acri_pkg::ST_BAD_GEOM;
		end else begin
			issue.status = acri_pkg::ST_OK;
		end
		issue.ctl      = side_fin.ctl;
		issue.pre      = side_fin.pre;
		issue.count    = side_fin.count;
		issue.sect     = acri_pkg::BYTE_W'(head_rem[N_HEAD]) + 8'd1;
		issue.cyl_lo   = side_fin.cyl[7:0];
		issue.cyl_hi   = side_fin.cyl[15:8];
		issue.drv_head = acri_pkg::DRVHEAD_BASE | {3'b000, side_fin.drive, 4'b0000}
			| {4'b0000, head_val[3:0]};
		issue.cmd      = side_fin.wr ? acri_pkg::CMD_WRITE : acri_pkg::CMD_READ;
	end

	acri_out_seq u_out_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (head_valid[N_HEAD]),
		.rec    (issue),
		.valid  (rsp_valid),
		.rsp    (rsp)
	);

`ifndef NO_ASSERTIONS
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.func == acri_pkg::FUNC_REQUEST |=> busy)
		else $error("busy not raised after a request");
`endif

endmodule

// File: tb/ata_chs_request_issuer_core_test.sv
`timescale 1ns / 1ps
// Self-checking test of ata_chs_request_issuer_core: loads partition entries, issues
// CHS requests under several drive geometries and checks every task-file write.
// Depends on acri_pkg and the core RTL only.
module ata_chs_request_issuer_core_test;
	import acri_pkg::*;

	localparam int NUM_DRIVES       = 2;
	localparam int MINORS_PER_DRIVE = 5;
	localparam int DEPTH            = NUM_DRIVES * MINORS_PER_DRIVE;
	localparam int SETTLE_CYCLES    = 24;
	localparam int STALL_LIMIT      = 2000;
	localparam int PHASE_ITEMS      = 34;

	// Predicts the task-file writes of each item and checks them in order
	class taskfile_board;
		logic [SECTOR_W-1:0]  part_first [DEPTH];
		logic [SECTOR_W-1:0]  part_len [DEPTH];
		logic [HEADS_W-1:0]   heads [NUM_DRIVES];
		logic [SPT_W-1:0]     spt [NUM_DRIVES];
		logic [PRECOMP_W-1:0] precomp [NUM_DRIVES];
		logic [BYTE_W-1:0]    ctl [NUM_DRIVES];
		rsp_t                 writes_due [$];
		int                   errors;

		function new();
			foreach (part_first[i]) begin
				part_first[i] = '0;
				part_len[i]   = '0;
			end
			foreach (heads[d]) begin
				heads[d]   = HEADS_RESET;
				spt[d]     = SPT_RESET;
				precomp[d] = '0;
				ctl[d]     = '0;
			end
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_HEADS0: begin
					heads[0] = data[HEADS_W-1:0];
				end
				CFG_SPT0: begin
					spt[0] = data[SPT_W-1:0];
				end
				CFG_HEADS1: begin
					heads[1] = data[HEADS_W-1:0];
				end
				CFG_SPT1: begin
					spt[1] = data[SPT_W-1:0];
				end
				CFG_PRECOMP0: begin
					precomp[0] = data[PRECOMP_W-1:0];
				end
				CFG_PRECOMP1: begin
					precomp[1] = data[PRECOMP_W-1:0];
				end
				CFG_CTRL0: begin
					ctl[0] = data[BYTE_W-1:0];
				end
				CFG_CTRL1: begin
					ctl[1] = data[BYTE_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function void push_write(logic [2:0] off, logic [BYTE_W-1:0] data, logic [1:0] st,
				logic last);
			rsp_t w;
			w.port_offset = off;
			w.port_data   = data;
			w.status      = st;
			w.last        = last;
			writes_due.push_back(w);
		endfunction

		// Work out the writes that one accepted item causes
		function void note_item(req_t it);
			logic [SECTOR_W:0]   reach;
			logic [SECTOR_W-1:0] lba, trk, cyl, hd, sect;
			int                  drv;
			if (it.func == FUNC_LOAD) begin
				if (it.minor < DEPTH) begin
					part_first[it.minor] = it.part_start;
					part_len[it.minor]   = it.part_size;
				end
				return;
			end
			if (it.minor >= DEPTH) begin
				push_write(REG_NONE, '0, ST_BAD_MINOR, 1'b1);
				return;
			end
			// range check is exact, no wrap
			reach = {1'b0, it.req_block} + (SECTOR_W+1)'(it.req_count);
			if (it.req_count == '0 || reach > {1'b0, part_len[it.minor]}) begin
				push_write(REG_NONE, '0, ST_BAD_RANGE, 1'b1);
				return;
			end
			lba = it.req_block + part_first[it.minor];
			drv = it.minor / MINORS_PER_DRIVE;
			if (drv >= NUM_DRIVES || heads[drv] == '0 || spt[drv] == '0) begin
				push_write(REG_NONE, '0, ST_BAD_GEOM, 1'b1);
				return;
			end
			trk  = SECTOR_W'(heads[drv]) * SECTOR_W'(spt[drv]);
			cyl  = lba / trk;
			hd   = (lba % trk) / SECTOR_W'(spt[drv]);
			sect = lba % SECTOR_W'(spt[drv]) + 1;
			if (hd > HEAD_MAX) begin
				push_write(REG_NONE, '0, ST_BAD_GEOM, 1'b1);
				return;
			end
			push_write(REG_CMD, ctl[drv], ST_OK, 1'b0);
			push_write(REG_PRECOMP, BYTE_W'(precomp[drv] >> 2), ST_OK, 1'b0);
			push_write(REG_COUNT, it.req_count, ST_OK, 1'b0);
			push_write(REG_SECTOR, BYTE_W'(sect), ST_OK, 1'b0);
			push_write(REG_CYL_LO, cyl[7:0], ST_OK, 1'b0);
			push_write(REG_CYL_HI, cyl[15:8], ST_OK, 1'b0);
			push_write(REG_DRV_HEAD, DRVHEAD_BASE | BYTE_W'(drv << 4) | BYTE_W'(hd), ST_OK,
				1'b0);
			push_write(REG_CMD, it.write_not_read ? CMD_WRITE : CMD_READ, ST_OK, 1'b1);
		endfunction

		function void field_check(string name, int want, int got);
			if (want != got) begin
				errors++;
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			end
		endfunction

		// Compare one write with the oldest expectation
		function void check_write(rsp_t got);
			rsp_t want;
			if (writes_due.size() == 0) begin
				errors++;
				$display("%0t: write with none expected: offset %0d data %0h status %0d last %0d",
					$time, got.port_offset, got.port_data, got.status, got.last);
				return;
			end
			want = writes_due.pop_front();
			field_check("port_offset", want.port_offset, got.port_offset);
			field_check("port_data", want.port_data, got.port_data);
			field_check("status", want.status, got.status);
			field_check("last", want.last, got.last);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	req_t                   req = '0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   rsp_valid;
	rsp_t                   rsp;
	int                     stall_cycles = 0;
	taskfile_board          board = new();

	ata_chs_request_issuer_core #(
		.NUM_DRIVES(NUM_DRIVES),
		.MINORS_PER_DRIVE(MINORS_PER_DRIVE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.rsp_valid(rsp_valid),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	// Check each write at the edge that ends its cycle
	always @(posedge clk) begin
		if (arst_n && rsp_valid)
			board.check_write(rsp);
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || rsp_valid || (start && !busy) || cfg_we) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 96)
			return $urandom_range(12, 4);
		return $urandom_range(40, 13);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] noisy(int v, int w);
		return CFG_DATA_W'(($urandom_range(1023) >> w) << w) | CFG_DATA_W'(v);
	endfunction

	function automatic req_t mk_load(int minor, logic [SECTOR_W-1:0] first,
			logic [SECTOR_W-1:0] len);
		req_t it;
		it.func           = FUNC_LOAD;
		it.minor          = MINOR_W'(minor);
		it.part_start     = first;
		it.part_size      = len;
		it.req_block      = $urandom;
		it.req_count      = COUNT_W'($urandom);
		it.write_not_read = 1'($urandom);
		return it;
	endfunction

	function automatic req_t mk_req(int minor, logic [SECTOR_W-1:0] blk, int cnt, int wr);
		req_t it;
		it.func           = FUNC_REQUEST;
		it.minor          = MINOR_W'(minor);
		it.part_start     = $urandom;
		it.part_size      = $urandom;
		it.req_block      = blk;
		it.req_count      = COUNT_W'(cnt);
		it.write_not_read = 1'(wr);
		return it;
	endfunction

	// Hold the item until the block takes it, then idle for gap cycles
	task automatic issue(input req_t it, input int gap);
		start <= 1'b1;
		req   <= it;
		do @(posedge clk); while (busy);
		board.note_item(it);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop start and wait for every expected write
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (board.writes_due.size() != 0);
	endtask

	// Loads leave no write behind, so allow the pipeline to empty as well
	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		board.set_reg(idx, v);
	endtask

	task automatic apply_geometry(input logic [CFG_DATA_W-1:0] h0, s0, h1, s1, p0, p1, c0, c1);
		write_reg(CFG_HEADS0, h0);
		write_reg(CFG_SPT0, s0);
		write_reg(CFG_HEADS1, h1);
		write_reg(CFG_SPT1, s1);
		write_reg(CFG_PRECOMP0, p0);
		write_reg(CFG_PRECOMP1, p1);
		write_reg(CFG_CTRL0, c0);
		write_reg(CFG_CTRL1, c1);
		cfg_we <= 1'b0;
	endtask

	// Mostly in-range requests, some loads, some noise; drain once midway
	task automatic run_phase();
		req_t                it;
		int                  m, cnt, pick;
		logic [SECTOR_W-1:0] blk;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			pick = $urandom_range(99);
			m    = $urandom_range(DEPTH - 1);
			if (pick < 12) begin
				it = mk_load($urandom_range(15), $urandom,
					($urandom_range(3) == 0) ? $urandom_range(300) : $urandom);
			end else if (pick < 88) begin
				cnt = $urandom_range(255, 1);
				if (board.part_len[m] >= cnt) begin
					if ($urandom_range(7) == 0)
						blk = board.part_len[m] - cnt;
					else
						blk = $urandom_range(board.part_len[m] - cnt, 0);
				end else begin
					blk = $urandom_range(3);
				end
				it = mk_req(m, blk, cnt, $urandom_range(1));
			end else begin
				it = mk_req($urandom_range(15), $urandom, $urandom_range(255), $urandom_range(1));
			end
			// a stretch of back-to-back items in every phase
			issue(it, (n >= 10 && n < 20) ? 0 : pick_gap());
			if (n == PHASE_ITEMS / 2)
				drain();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items under the reset geometry
		issue(mk_load(0, 32'h0, 32'hffff_ffff), pick_gap());
		issue(mk_load(4, 32'hffff_fff0, 32'd1000), pick_gap());
		issue(mk_load(5, 32'd12345, 32'd100), pick_gap());
		issue(mk_load(9, 32'hffff_ffff, 32'hffff_ffff), pick_gap());
		issue(mk_load(12, 32'd5, 32'd5), pick_gap());
		issue(mk_req(0, 32'h0, 1, 0), pick_gap());
		issue(mk_req(0, 32'hffff_ff00, 255, 1), pick_gap());
		issue(mk_req(0, 32'hffff_ffff, 255, 0), pick_gap());
		issue(mk_req(0, 32'd5, 0, 1), pick_gap());
		issue(mk_req(4, 32'h20, 8, 0), pick_gap());
		issue(mk_req(4, 32'd992, 8, 1), pick_gap());
		issue(mk_req(4, 32'd993, 8, 0), pick_gap());
		issue(mk_req(5, 32'd99, 1, 1), pick_gap());
		issue(mk_req(9, 32'hffff_fffe, 1, 0), pick_gap());
		issue(mk_req(12, 32'h0, 1, 0), pick_gap());
		issue(mk_req(15, 32'hffff_ffff, 255, 1), pick_gap());
		issue(mk_req(10, 32'h0, 1, 0), pick_gap());
		issue(mk_req(1, 32'h0, 1, 1), pick_gap());
		issue(mk_load(1, 32'h0, 32'd255), pick_gap());
		issue(mk_req(1, 32'h0, 255, 1), pick_gap());
		run_phase();

		// Smallest geometry on drive 0, largest precomp and control byte
		settle();
		apply_geometry(1, 1, 16, 63, 1023, 0, 255, 0);
		run_phase();

		// Oversized head count on drive 0, zero heads on drive 1
		settle();
		apply_geometry(noisy(31, HEADS_W), noisy(63, SPT_W), noisy(0, HEADS_W), noisy(1, SPT_W),
			0, 1023, noisy(0, BYTE_W), noisy(255, BYTE_W));
		run_phase();

		// Zero sectors per track on drive 0
		settle();
		apply_geometry(noisy(16, HEADS_W), noisy(0, SPT_W), noisy(1, HEADS_W), noisy(63, SPT_W),
			CFG_DATA_W'($urandom_range(1023)), CFG_DATA_W'($urandom_range(1023)),
			noisy($urandom_range(255), BYTE_W), noisy($urandom_range(255), BYTE_W));
		run_phase();

		// Random legal geometries
		repeat (3) begin
			settle();
			apply_geometry(noisy($urandom_range(16, 1), HEADS_W),
				noisy($urandom_range(63, 1), SPT_W),
				noisy($urandom_range(16, 1), HEADS_W),
				noisy($urandom_range(63, 1), SPT_W),
				CFG_DATA_W'($urandom_range(1023)), CFG_DATA_W'($urandom_range(1023)),
				noisy($urandom_range(255), BYTE_W), noisy($urandom_range(255), BYTE_W));
			run_phase();
		end

		settle();
		if (board.errors == 0 && board.writes_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
